### hdl/assert_macros.svh
// Assertion macros shared by the RTL of the raindrop block.
// Empty when SYNTHESIS is defined; otherwise clocked on clk_i with reset rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Checked only while out of reset.
`define RDE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("raindrop assertion failed");
// Checked at every edge, reset included.
`define RDE_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("raindrop assertion failed");
`else
`define RDE_ASSERT(lbl, prop)
`define RDE_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

### hdl/rde_pkg.sv
// Package for the LED raindrop block: payload and state types, register
// indexes, sizing constants and the range pick function. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rde_pkg;

  localparam int NUM_LEDS    = 256;
  localparam int LED_AW      = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
  localparam int BRIGHT_FULL = 65535;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 21;

  localparam logic [16:0] Q16_ONE = 17'h10000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHANCE     = 3'd0,
    CFG_HUE_LOW    = 3'd1,
    CFG_HUE_HIGH   = 3'd2,
    CFG_SAT_LOW    = 3'd3,
    CFG_SAT_HIGH   = 3'd4,
    CFG_BRIGHT_LOW = 3'd5,
    CFG_FADE_LOW   = 3'd6,
    CFG_FADE_HIGH  = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0]  led_index;
    logic [19:0] roll;
    logic [15:0] rand_hue;
    logic [15:0] rand_sat;
    logic [15:0] rand_bright;
    logic [15:0] rand_fade;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_index;
    logic [8:0]  out_hue;
    logic [9:0]  out_sat;
    logic [15:0] out_bright;
  } out_item_t;

  typedef struct packed {
    logic [20:0] chance_q20;
    logic [8:0]  hue_low;
    logic [8:0]  hue_high;
    logic [9:0]  sat_low;
    logic [9:0]  sat_high;
    logic [15:0] bright_low;
    logic [16:0] fade_low;
    logic [16:0] fade_high;
  } cfg_t;

  // One LED's stored state, also the memory word.
  typedef struct packed {
    logic [8:0]  hue;
    logic [9:0]  sat;
    logic [15:0] bright;
    logic [16:0] fade;
  } entry_t;

  // Draw for one item: hit flag and the freshly picked drop.
  typedef struct packed {
    logic   hit;
    entry_t drop;
  } draw_t;

  // lo + ((r * (hi - lo + 1)) >> 16), or lo when hi < lo
  function automatic logic [16:0] pick17(logic [16:0] lo, logic [16:0] hi,
                                         logic [15:0] r);
    logic [17:0] span;
    logic [33:0] prod;
    logic [16:0] res;
    span = {1'b0, hi} - {1'b0, lo} + 18'd1;
    prod = 34'(r) * 34'(span);
    if (hi < lo) begin
      res = lo;
    end else begin
      res = lo + prod[32:16];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

### hdl/rde_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Read before write on the same address. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module rde_ram #(
  parameter int DW    = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [DW-1:0] wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### hdl/rde_draw.sv
// Hit test and range picks for one item, registered alongside the memory read.
// Depends on rde_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rde_draw
  import rde_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     en_i,
  input  wire in_item_t item_i,
  input  wire cfg_t     cfg_i,
  output draw_t         draw_o
);

  logic [20:0] roll_sum;
  logic [16:0] hue_pick, sat_pick, bright_pick, fade_pick;
  draw_t       draw_d, draw_q;

  // roll >= 2^20 - chance  <=>  roll + chance carries into bit 20
  assign roll_sum = {1'b0, item_i.roll} + {1'b0, cfg_i.chance_q20[19:0]};

  assign hue_pick    = pick17(17'(cfg_i.hue_low), 17'(cfg_i.hue_high), item_i.rand_hue);
  assign sat_pick    = pick17(17'(cfg_i.sat_low), 17'(cfg_i.sat_high), item_i.rand_sat);
  assign bright_pick = pick17(17'(cfg_i.bright_low), 17'(BRIGHT_FULL), item_i.rand_bright);
  assign fade_pick   = pick17(cfg_i.fade_low, cfg_i.fade_high, item_i.rand_fade);

  always_comb begin
    draw_d.hit         = cfg_i.chance_q20[20] | roll_sum[20];
    draw_d.drop.hue    = hue_pick[8:0];
    draw_d.drop.sat    = sat_pick[9:0];
    draw_d.drop.bright = bright_pick[15:0];
    draw_d.drop.fade   = fade_pick;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      draw_q <= draw_d;
    end
  end

  assign draw_o = draw_q;

endmodule

`default_nettype wire

### hdl/led_raindrop_effect.sv
// Top level of the LED raindrop block: config registers, per-LED state memory
// with forwarding, fade stage and output register. Depends on rde_pkg,
// rde_ram, rde_draw and assert_macros.svh.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+--------------------------------
//   input    | in_valid_i / in_ready_o | in_data_i  (in_item_t)
//   output   | out_valid_o/out_ready_i | out_data_o (out_item_t)
//   config   | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One item per cycle while the output is not blocked; an input transfer passes through
// the memory read and draw, then the merge, then fade, write-back and output register
// together before out_valid_o rises.
// The state memory has one write and one read port; read-modify-write hazards
// are covered by forwarding from the write stage and the last write.
// Reset clears a valid flag per LED, so no clearing pass is needed.
// A held output freezes the pipe only once the write stage is occupied.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module led_raindrop_effect
  import rde_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire in_item_t             in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output out_item_t                 out_data_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_DAT_W-1:0] cfg_data_i
);

  // ---------------- configuration ----------------
  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.chance_q20 <= 21'd996147;
      cfg_q.hue_low    <= 9'd0;
      cfg_q.hue_high   <= 9'd360;
      cfg_q.sat_low    <= 10'd0;
      cfg_q.sat_high   <= 10'd1000;
      cfg_q.bright_low <= 16'd52429;
      cfg_q.fade_low   <= 17'd52429;
      cfg_q.fade_high  <= 17'd32768;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_CHANCE:     cfg_q.chance_q20 <= cfg_data_i[20:0];
        CFG_HUE_LOW:    cfg_q.hue_low    <= cfg_data_i[8:0];
        CFG_HUE_HIGH:   cfg_q.hue_high   <= cfg_data_i[8:0];
        CFG_SAT_LOW:    cfg_q.sat_low    <= cfg_data_i[9:0];
        CFG_SAT_HIGH:   cfg_q.sat_high   <= cfg_data_i[9:0];
        CFG_BRIGHT_LOW: cfg_q.bright_low <= cfg_data_i[15:0];
        CFG_FADE_LOW:   cfg_q.fade_low   <= cfg_data_i[16:0];
        CFG_FADE_HIGH:  cfg_q.fade_high  <= cfg_data_i[16:0];
        default: ;
      endcase
    end
  end

  // ---------------- pipeline control ----------------
  logic s1_valid_q, s2_valid_q, out_valid_q, w3_valid_q;
  logic adv, acc;

  // Advance unless the write stage holds an item and the output is blocked.
  assign adv        = out_ready_i || !out_valid_q || !s2_valid_q;
  assign in_ready_o = adv;
  assign acc        = in_valid_i && in_ready_o;

  // ---------------- stage 0: address, read, draw ----------------
  logic [31:0]       idx_wide;
  logic [LED_AW-1:0] s0_addr;
  logic              s0_inr;

  assign idx_wide = 32'(in_data_i.led_index);
  assign s0_addr  = idx_wide[LED_AW-1:0];
  assign s0_inr   = (idx_wide < 32'(NUM_LEDS));

  logic              ram_we;
  logic [LED_AW-1:0] s2_addr_q;
  entry_t            wentry;
  logic [$bits(entry_t)-1:0] ram_rdata;

  rde_ram #(
    .DW    ($bits(entry_t)),
    .DEPTH (NUM_LEDS),
    .AW    (LED_AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s2_addr_q),
    .wdata_i (wentry),
    .re_i    (adv),
    .raddr_i (s0_addr),
    .rdata_o (ram_rdata)
  );

  draw_t s1_draw;

  rde_draw u_draw (
    .clk_i  (clk_i),
    .en_i   (adv),
    .item_i (in_data_i),
    .cfg_i  (cfg_q),
    .draw_o (s1_draw)
  );

  // Written flags per LED; an unwritten LED reads as zero.
  logic [NUM_LEDS-1:0] vld_q;
  logic                s1_rd_vld_q;
  logic [7:0]          s1_idx_q;
  logic [LED_AW-1:0]   s1_addr_q;
  logic                s1_inr_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_rd_vld_q <= vld_q[s0_addr];
      s1_idx_q    <= in_data_i.led_index;
      s1_addr_q   <= s0_addr;
      s1_inr_q    <= s0_inr;
    end
  end

  // ---------------- stage 1: forward and merge ----------------
  entry_t            s2_entry_q, w3_entry_q, s1_old, s1_cur;
  logic [LED_AW-1:0] w3_addr_q;
  logic [7:0]        s2_idx_q;
  logic              s2_inr_q;

  always_comb begin
    priority if (s2_valid_q && s2_inr_q && (s2_addr_q == s1_addr_q)) begin
      s1_old = wentry;
    end else if (w3_valid_q && (w3_addr_q == s1_addr_q)) begin
      s1_old = w3_entry_q;
    end else if (s1_rd_vld_q) begin
      s1_old = entry_t'(ram_rdata);
    end else begin
      s1_old = '0;
    end
    s1_cur = s1_draw.hit ? s1_draw.drop : s1_old;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_entry_q <= s1_cur;
      s2_idx_q   <= s1_idx_q;
      s2_addr_q  <= s1_addr_q;
      s2_inr_q   <= s1_inr_q;
    end
  end

  // ---------------- stage 2: fade and write back ----------------
  logic [16:0] rate;
  logic [32:0] faded;

  assign rate  = (s2_entry_q.fade > Q16_ONE) ? Q16_ONE : s2_entry_q.fade;
  assign faded = 33'(s2_entry_q.bright) * 33'(rate);

  always_comb begin
    wentry        = s2_entry_q;
    wentry.bright = faded[31:16];
  end

  assign ram_we = adv && s2_valid_q && s2_inr_q;

  // Last write, which the read issued at the same edge did not see.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      w3_entry_q <= wentry;
      w3_addr_q  <= s2_addr_q;
    end
  end

  out_item_t out_q;

  always_ff @(posedge clk_i) begin
    if (adv && s2_valid_q) begin
      out_q.out_index  <= s2_idx_q;
      out_q.out_hue    <= s2_inr_q ? s2_entry_q.hue : 9'd0;
      out_q.out_sat    <= s2_inr_q ? s2_entry_q.sat : 10'd0;
      out_q.out_bright <= s2_inr_q ? s2_entry_q.bright : 16'd0;
    end
  end

  logic out_valid_d;

  always_comb begin
    priority if (adv && s2_valid_q) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      w3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      vld_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      if (adv) begin
        s1_valid_q <= acc;
        s2_valid_q <= s1_valid_q;
        w3_valid_q <= s2_valid_q && s2_inr_q;
      end
      if (ram_we) begin
        vld_q[s2_addr_q] <= 1'b1;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------- assertions ----------------
  `RDE_ASSERT(a_acc_enters_s1, acc |=> s1_valid_q)
  `RDE_ASSERT(a_full_stall_blocks, (s2_valid_q && out_valid_q && !out_ready_i) |-> !in_ready_o)
  `RDE_ASSERT(a_write_sets_flag, ram_we |=> vld_q[$past(s2_addr_q)])
  `RDE_ASSERT_ALWAYS(a_no_write_in_reset, !rst_ni |=> !s2_valid_q)

endmodule

`default_nettype wire

### tb/led_raindrop_effect_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for led_raindrop_effect: directed and random LED items
// against a cycle-free colour predictor, with random idling on the input and output channels.
// Depends on rde_pkg and the RTL of the block.

module led_raindrop_effect_tb;
  import rde_pkg::*;

  localparam int unsigned ROLL_SPAN      = 32'd1 << 20;
  localparam int          PIPE_LATENCY   = 3;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          RANDOM_PHASES  = 6;
  localparam int          PHASE_ITEMS    = 300;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_ready;
  out_item_t            out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  // Predictor state: shadow registers and per-LED drop memory
  cfg_t        shadow_cfg;
  logic [8:0]  drop_hue    [NUM_LEDS];
  logic [9:0]  drop_sat    [NUM_LEDS];
  logic [15:0] drop_bright [NUM_LEDS];
  logic [16:0] drop_fade   [NUM_LEDS];

  out_item_t pending_colours[$];
  bit        allow_idle;
  int        error_count;
  int        items_sent;
  int        colours_checked;
  int        setting_writes;
  int        watchdog_idle;

  led_raindrop_effect u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #2 clk = ~clk;

  // lo + ((r * (hi - lo + 1)) >> 16), or lo for an inverted range
  function automatic logic [16:0] pick_in_range(input logic [16:0] lo, input logic [16:0] hi,
                                                input logic [15:0] r);
    longint unsigned lo_w;
    longint unsigned hi_w;
    longint unsigned r_w;
    lo_w = lo;
    hi_w = hi;
    r_w  = r;
    if (hi_w < lo_w) return lo;
    return 17'(lo_w + ((r_w * (hi_w - lo_w + 1)) >> 16));
  endfunction

  function automatic out_item_t predict_colour(input in_item_t item);
    out_item_t   res;
    int unsigned idx;
    bit          hit;
    logic [16:0] rate;
    logic [32:0] prod;
    idx           = item.led_index;
    res           = '0;
    res.out_index = item.led_index;
    if (idx >= NUM_LEDS) return res;
    if (shadow_cfg.chance_q20 >= ROLL_SPAN) begin
      hit = 1'b1;
    end else begin
      hit = item.roll >= ROLL_SPAN - shadow_cfg.chance_q20;
    end
    if (hit) begin
      drop_hue[idx]    = 9'(pick_in_range(17'(shadow_cfg.hue_low), 17'(shadow_cfg.hue_high),
                                          item.rand_hue));
      drop_sat[idx]    = 10'(pick_in_range(17'(shadow_cfg.sat_low), 17'(shadow_cfg.sat_high),
                                           item.rand_sat));
      drop_bright[idx] = 16'(pick_in_range(17'(shadow_cfg.bright_low), 17'(BRIGHT_FULL),
                                           item.rand_bright));
      drop_fade[idx]   = pick_in_range(shadow_cfg.fade_low, shadow_cfg.fade_high,
                                       item.rand_fade);
    end
    res.out_hue    = drop_hue[idx];
    res.out_sat    = drop_sat[idx];
    res.out_bright = drop_bright[idx];
    // fade after the colour is taken; a rate above one is clamped
    rate = (drop_fade[idx] > Q16_ONE) ? Q16_ONE : drop_fade[idx];
    prod = drop_bright[idx] * rate;
    drop_bright[idx] = prod[31:16];
    return res;
  endfunction

  function automatic in_item_t make_item(input int unsigned idx, input int unsigned roll,
                                         input int unsigned h, input int unsigned s,
                                         input int unsigned b, input int unsigned f);
    in_item_t item;
    item.led_index   = 8'(idx);
    item.roll        = 20'(roll);
    item.rand_hue    = 16'(h);
    item.rand_sat    = 16'(s);
    item.rand_bright = 16'(b);
    item.rand_fade   = 16'(f);
    return item;
  endfunction

  function automatic in_item_t random_item();
    in_item_t    item;
    int unsigned threshold;
    item = make_item($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    // favour a few LEDs so drops and fades stack up on the same entry
    if ($urandom_range(0, 1)) item.led_index = 8'($urandom_range(0, 7));
    if ($urandom_range(0, 6) == 0 && shadow_cfg.chance_q20 < ROLL_SPAN) begin
      threshold = ROLL_SPAN - shadow_cfg.chance_q20;
      item.roll = 20'(threshold + $urandom_range(0, 2) - 1);
    end
    return item;
  endfunction

  function automatic logic [CFG_DAT_W-1:0] draw_setting(input int unsigned lo,
                                                        input int unsigned hi,
                                                        input int unsigned rst_val,
                                                        input int unsigned width);
    int unsigned sel;
    sel = $urandom_range(0, 19);
    if (sel < 5) return CFG_DAT_W'(rst_val);
    if (sel < 8) return CFG_DAT_W'(lo);
    if (sel < 11) return CFG_DAT_W'(hi);
    if (sel < 18) return CFG_DAT_W'($urandom_range(hi, lo));
    return CFG_DAT_W'($urandom & ((32'd1 << width) - 1));
  endfunction

  task automatic send_led_item(input in_item_t item);
    int gap;
    gap = allow_idle ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  = item;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_colours.push_back(predict_colour(item));
    items_sent++;
    @(negedge clk);
  endtask

  // Drop valid and let the pipe empty before touching a register
  task automatic settle();
    in_valid = 1'b0;
    while (pending_colours.size() != 0) @(negedge clk);
    repeat (PIPE_LATENCY + 2) @(negedge clk);
  endtask

  task automatic write_setting(input cfg_reg_e reg_id, input logic [CFG_DAT_W-1:0] value);
    cfg_valid = 1'b1;
    cfg_index = reg_id;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    case (reg_id)
      CFG_CHANCE:     shadow_cfg.chance_q20 = value[20:0];
      CFG_HUE_LOW:    shadow_cfg.hue_low    = value[8:0];
      CFG_HUE_HIGH:   shadow_cfg.hue_high   = value[8:0];
      CFG_SAT_LOW:    shadow_cfg.sat_low    = value[9:0];
      CFG_SAT_HIGH:   shadow_cfg.sat_high   = value[9:0];
      CFG_BRIGHT_LOW: shadow_cfg.bright_low = value[15:0];
      CFG_FADE_LOW:   shadow_cfg.fade_low   = value[16:0];
      CFG_FADE_HIGH:  shadow_cfg.fade_high  = value[16:0];
      default: ;
    endcase
    setting_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic write_ranges(input int unsigned hue_lo, input int unsigned hue_hi,
                              input int unsigned sat_lo, input int unsigned sat_hi,
                              input int unsigned bright_lo, input int unsigned fade_lo,
                              input int unsigned fade_hi);
    write_setting(CFG_HUE_LOW, CFG_DAT_W'(hue_lo));
    write_setting(CFG_HUE_HIGH, CFG_DAT_W'(hue_hi));
    write_setting(CFG_SAT_LOW, CFG_DAT_W'(sat_lo));
    write_setting(CFG_SAT_HIGH, CFG_DAT_W'(sat_hi));
    write_setting(CFG_BRIGHT_LOW, CFG_DAT_W'(bright_lo));
    write_setting(CFG_FADE_LOW, CFG_DAT_W'(fade_lo));
    write_setting(CFG_FADE_HIGH, CFG_DAT_W'(fade_hi));
  endtask

  task automatic check_colour(input out_item_t got);
    out_item_t want;
    if (pending_colours.size() == 0) begin
      error_count++;
      $display("%0t: colour for LED %0d with none outstanding", $time, got.out_index);
      return;
    end
    want = pending_colours.pop_front();
    colours_checked++;
    if (got.out_index !== want.out_index) begin
      error_count++;
      $display("%0t: out_index expected %0d, got %0d", $time, want.out_index, got.out_index);
    end
    if (got.out_hue !== want.out_hue) begin
      error_count++;
      $display("%0t: out_hue (LED %0d) expected %0d, got %0d", $time, want.out_index,
               want.out_hue, got.out_hue);
    end
    if (got.out_sat !== want.out_sat) begin
      error_count++;
      $display("%0t: out_sat (LED %0d) expected %0d, got %0d", $time, want.out_index,
               want.out_sat, got.out_sat);
    end
    if (got.out_bright !== want.out_bright) begin
      error_count++;
      $display("%0t: out_bright (LED %0d) expected %0d, got %0d", $time, want.out_index,
               want.out_bright, got.out_bright);
    end
  endtask

  // Fresh state: misses must read back all-zero colours
  task automatic test_reset_state();
    allow_idle = 1'b1;
    send_led_item(make_item(0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_led_item(make_item(255, 0, 0, 0, 0, 0));
    send_led_item(make_item(17, 52428, 16'h1234, 16'h4321, 16'h5555, 16'hAAAA));
  endtask

  // Roll either side of the threshold, then back-to-back fades on one LED
  task automatic test_hit_threshold();
    allow_idle = 1'b0;
    send_led_item(make_item(5, 52428, 0, 0, 0, 0));
    send_led_item(make_item(5, 52429, 0, 0, 0, 0));
    repeat (3) send_led_item(make_item(5, 0, 0, 0, 0, 0));
    send_led_item(make_item(5, 20'hFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    allow_idle = 1'b1;
    repeat (2) send_led_item(make_item(5, 0, 16'hFFFF, 0, 16'hFFFF, 0));
  endtask

  task automatic test_setting_extremes();
    allow_idle = 1'b1;
    settle();
    // never hits
    write_setting(CFG_CHANCE, '0);
    send_led_item(make_item(9, 20'hFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    // inverted and over-range bounds, rate above one
    settle();
    write_setting(CFG_CHANCE, 21'h1FFFFF);
    write_ranges(300, 10, 1023, 1023, 65535, 131071, 131071);
    send_led_item(make_item(9, 0, 16'h8000, 16'h0001, 16'hFFFF, 16'hFFFF));
    settle();
    write_setting(CFG_CHANCE, '0);
    repeat (2) send_led_item(make_item(9, 0, 0, 0, 0, 0));
    // widest ranges, zero fade wipes the drop after one frame
    settle();
    write_setting(CFG_CHANCE, CFG_DAT_W'(ROLL_SPAN));
    write_ranges(0, 511, 0, 1023, 0, 0, 0);
    send_led_item(make_item(255, 20'h00000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    settle();
    write_setting(CFG_CHANCE, '0);
    send_led_item(make_item(255, 20'hFFFFF, 0, 0, 0, 0));
    // chance just below one: only roll zero misses
    settle();
    write_setting(CFG_CHANCE, CFG_DAT_W'(ROLL_SPAN - 1));
    write_ranges(0, 360, 0, 1000, 52429, 52429, 32768);
    send_led_item(make_item(3, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_led_item(make_item(3, 1, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
  endtask

  task automatic randomise_settings();
    write_setting(CFG_CHANCE, draw_setting(0, ROLL_SPAN, 996147, 21));
    write_setting(CFG_HUE_LOW, draw_setting(0, 360, 0, 9));
    write_setting(CFG_HUE_HIGH, draw_setting(0, 360, 360, 9));
    write_setting(CFG_SAT_LOW, draw_setting(0, 1000, 0, 10));
    write_setting(CFG_SAT_HIGH, draw_setting(0, 1000, 1000, 10));
    write_setting(CFG_BRIGHT_LOW, draw_setting(0, 65535, 52429, 16));
    write_setting(CFG_FADE_LOW, draw_setting(0, 65536, 52429, 17));
    write_setting(CFG_FADE_HIGH, draw_setting(0, 65536, 32768, 17));
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      settle();
      randomise_settings();
      // phases without idling keep the pipe full
      allow_idle = (phase % 3) != 2;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 1 && n == PHASE_ITEMS / 2) begin
          in_valid = 1'b0;
          while (pending_colours.size() != 0) @(negedge clk);
        end
        send_led_item(random_item());
      end
    end
  endtask

  // Result side: random stall per transfer while idling is allowed, check at each transfer
  initial begin : colour_sink
    int stall;
    wait (rst_n);
    forever begin
      stall = allow_idle ? $urandom_range(0, 4) : 0;
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      check_colour(out_data);
      @(negedge clk);
    end
  end

  initial begin : watchdog
    watchdog_idle = 0;
    while (watchdog_idle < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        watchdog_idle = 0;
      else
        watchdog_idle++;
    end
    $display("%0t: no transfer for %0d cycles, %0d colours outstanding", $time,
             WATCHDOG_LIMIT, pending_colours.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    clk             = 1'b0;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_data         = '0;
    out_ready       = 1'b0;
    cfg_valid       = 1'b0;
    cfg_index       = CFG_CHANCE;
    cfg_data        = '0;
    allow_idle      = 1'b1;
    error_count     = 0;
    items_sent      = 0;
    colours_checked = 0;
    setting_writes  = 0;
    shadow_cfg      = '{chance_q20: 21'd996147, hue_low: 9'd0, hue_high: 9'd360,
                        sat_low: 10'd0, sat_high: 10'd1000, bright_low: 16'd52429,
                        fade_low: 17'd52429, fade_high: 17'd32768};
    for (int i = 0; i < NUM_LEDS; i++) begin
      drop_hue[i]    = '0;
      drop_sat[i]    = '0;
      drop_bright[i] = '0;
      drop_fade[i]   = '0;
    end
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_reset_state();
    test_hit_threshold();
    test_setting_extremes();
    test_random_traffic();

    settle();
    repeat (4 * PIPE_LATENCY) @(negedge clk);
    $display("Sent %0d LED items and checked %0d colours over %0d register writes,",
             items_sent, colours_checked, setting_writes);
    $display("covering threshold rolls, inverted and over-range bounds and fade clamping.");
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### led_raindrop_effect.f
+incdir+hdl
hdl/rde_pkg.sv
hdl/rde_ram.sv
hdl/rde_draw.sv
hdl/led_raindrop_effect.sv
tb/led_raindrop_effect_tb.sv
